// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_ALWAYS(label, expr)
`define CHK_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps
package mi3_pkg;
  localparam int IN_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH_DEF = 32;
  localparam int IN_FRAC       = 8;
  localparam int OUT_FRAC      = 16;
  localparam int DIV_SHIFT     = OUT_FRAC + IN_FRAC;
  localparam int PASS_SHIFT    = OUT_FRAC - IN_FRAC;
  localparam int NUM_ELEM      = 9;
endpackage

// ===== rtl/mi3_cofactor.sv =====
`timescale 1ns / 1ps
module mi3_cofactor #(
  parameter int IN_WIDTH = mi3_pkg::IN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [IN_WIDTH-1:0]    m     [mi3_pkg::NUM_ELEM],
  output logic signed [2*IN_WIDTH:0]    adj   [mi3_pkg::NUM_ELEM],
  output logic signed [3*IN_WIDTH+2:0]  det,
  output logic signed [IN_WIDTH-1:0]    m_out [mi3_pkg::NUM_ELEM]
);
  localparam int PW = 2 * IN_WIDTH;
  localparam int AW = PW + 1;
  localparam int TW = IN_WIDTH + AW;
  localparam int DW = TW + 2;

  logic signed [PW-1:0]       p    [2*mi3_pkg::NUM_ELEM];
  logic signed [IN_WIDTH-1:0] m1   [mi3_pkg::NUM_ELEM];
  logic signed [AW-1:0]       adj2 [mi3_pkg::NUM_ELEM];
  logic signed [IN_WIDTH-1:0] m2   [mi3_pkg::NUM_ELEM];
  logic signed [TW-1:0]       t0;
  logic signed [TW-1:0]       t1;
  logic signed [TW-1:0]       t2;
  logic signed [AW-1:0]       adj3 [mi3_pkg::NUM_ELEM];
  logic signed [IN_WIDTH-1:0] m3   [mi3_pkg::NUM_ELEM];

  // products for the nine 2x2 minors
  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= m[4] * m[8];
      p[1]  <= m[5] * m[7];
      p[2]  <= m[2] * m[7];
      p[3]  <= m[1] * m[8];
      p[4]  <= m[1] * m[5];
      p[5]  <= m[2] * m[4];
      p[6]  <= m[5] * m[6];
      p[7]  <= m[3] * m[8];
      p[8]  <= m[0] * m[8];
      p[9]  <= m[2] * m[6];
      p[10] <= m[2] * m[3];
      p[11] <= m[0] * m[5];
      p[12] <= m[3] * m[7];
      p[13] <= m[4] * m[6];
      p[14] <= m[1] * m[6];
      p[15] <= m[0] * m[7];
      p[16] <= m[0] * m[4];
      p[17] <= m[1] * m[3];
      m1 <= m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
        adj2[i] <= AW'(p[2*i]) - AW'(p[2*i+1]);
      end
      m2 <= m1;
    end
  end

  // cofactor expansion along row 0
  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= m2[0] * adj2[0];
      t1 <= m2[1] * adj2[3];
      t2 <= m2[2] * adj2[6];
      adj3 <= adj2;
      m3 <= m2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= DW'(t0) + DW'(t1) + DW'(t2);
      adj <= adj3;
      m_out <= m3;
    end
  end
endmodule

// ===== rtl/mi3_div_lane.sv =====
`timescale 1ns / 1ps
module mi3_div_lane #(
  parameter int IN_WIDTH  = mi3_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = mi3_pkg::OUT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [2*IN_WIDTH:0]    adj,
  input  logic signed [3*IN_WIDTH+2:0]  det,
  input  logic signed [IN_WIDTH-1:0]    m,
  output logic        [OUT_WIDTH-1:0]   res,
  output logic                          sing
);
  localparam int AW = 2 * IN_WIDTH + 1;
  localparam int DW = IN_WIDTH + AW + 2;
  localparam int NW = AW + mi3_pkg::DIV_SHIFT;
  localparam int XW = ((NW > OUT_WIDTH) ? NW : OUT_WIDTH) + 1;
  localparam logic signed [XW-1:0] MAXX =
    $signed({{(XW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}});
  localparam logic signed [XW-1:0] MINX = ~MAXX;

  logic [DW-1:0]              rem_s  [NW+1];
  logic [NW-1:0]              q_s    [NW+1];
  logic [DW-1:0]              d_s    [NW+1];
  logic                       neg_s  [NW+1];
  logic                       sing_s [NW+1];
  logic signed [IN_WIDTH-1:0] m_s    [NW+1];

  logic signed [XW-1:0] qx;
  logic signed [XW-1:0] sq;
  logic signed [XW-1:0] pv;
  logic signed [XW-1:0] val;

  // magnitudes and sign of the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= '0;
      q_s[0]    <= {(adj[AW-1] ? $unsigned(-adj) : $unsigned(adj)),
                    {mi3_pkg::DIV_SHIFT{1'b0}}};
      d_s[0]    <= det[DW-1] ? $unsigned(-det) : $unsigned(det);
      neg_s[0]  <= adj[AW-1] ^ det[DW-1];
      sing_s[0] <= (det == '0);
      m_s[0]    <= m;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic [DW:0] t;
    logic [DW:0] diff;

    always_comb begin
      t    = {rem_s[k], q_s[k][NW-1]};
      diff = t - {1'b0, d_s[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW]) begin
          rem_s[k+1] <= diff[DW-1:0];
          q_s[k+1]   <= {q_s[k][NW-2:0], 1'b1};
        end else begin
          rem_s[k+1] <= t[DW-1:0];
          q_s[k+1]   <= {q_s[k][NW-2:0], 1'b0};
        end
        d_s[k+1]    <= d_s[k];
        neg_s[k+1]  <= neg_s[k];
        sing_s[k+1] <= sing_s[k];
        m_s[k+1]    <= m_s[k];
      end
    end
  end

  // sign, passthrough select and saturation
  always_comb begin
    qx  = $signed({{(XW-NW){1'b0}}, q_s[NW]});
    sq  = neg_s[NW] ? -qx : qx;
    pv  = XW'(m_s[NW]) <<< mi3_pkg::PASS_SHIFT;
    val = sing_s[NW] ? pv : sq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (val > MAXX) begin
        res <= MAXX[OUT_WIDTH-1:0];
      end else if (val < MINX) begin
        res <= MINX[OUT_WIDTH-1:0];
      end else begin
        res <= val[OUT_WIDTH-1:0];
      end
      sing <= sing_s[NW];
    end
  end
endmodule

// ===== rtl/matrix_inverse_3x3_top.sv =====
// results enter the output buffer in input order after the cofactor and divider stages
// throughput: one matrix per cycle while the output buffer is not full, set by the nine pipelined divider lanes
// the divider lanes resolve one quotient bit per stage over 2*IN_WIDTH + 25 stages
// a two-entry output buffer keeps input flowing while one result waits
// reset (synchronous) clears the valid pipeline and the output buffer pointers and count
`timescale 1ns / 1ps
`include "assert_macros.svh"
module matrix_inverse_3x3_top #(
  parameter int IN_WIDTH  = mi3_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = mi3_pkg::OUT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [IN_WIDTH-1:0]  a00,
  input  logic signed [IN_WIDTH-1:0]  a01,
  input  logic signed [IN_WIDTH-1:0]  a02,
  input  logic signed [IN_WIDTH-1:0]  a10,
  input  logic signed [IN_WIDTH-1:0]  a11,
  input  logic signed [IN_WIDTH-1:0]  a12,
  input  logic signed [IN_WIDTH-1:0]  a20,
  input  logic signed [IN_WIDTH-1:0]  a21,
  input  logic signed [IN_WIDTH-1:0]  a22,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0] inv00,
  output logic signed [OUT_WIDTH-1:0] inv01,
  output logic signed [OUT_WIDTH-1:0] inv02,
  output logic signed [OUT_WIDTH-1:0] inv10,
  output logic signed [OUT_WIDTH-1:0] inv11,
  output logic signed [OUT_WIDTH-1:0] inv12,
  output logic signed [OUT_WIDTH-1:0] inv20,
  output logic signed [OUT_WIDTH-1:0] inv21,
  output logic signed [OUT_WIDTH-1:0] inv22,
  output logic                        singular
);
  localparam int AW  = 2 * IN_WIDTH + 1;
  localparam int DW  = IN_WIDTH + AW + 2;
  localparam int NW  = AW + mi3_pkg::DIV_SHIFT;
  localparam int LAT = NW + 6;

  logic                       en;
  logic [LAT-1:0]             vpipe;
  logic signed [IN_WIDTH-1:0] m_in  [mi3_pkg::NUM_ELEM];
  logic signed [AW-1:0]       adj   [mi3_pkg::NUM_ELEM];
  logic signed [DW-1:0]       det;
  logic signed [IN_WIDTH-1:0] m_d   [mi3_pkg::NUM_ELEM];
  logic [OUT_WIDTH-1:0]       res   [mi3_pkg::NUM_ELEM];
  logic [mi3_pkg::NUM_ELEM-1:0] sing;

  logic [mi3_pkg::NUM_ELEM-1:0][OUT_WIDTH-1:0] buf_inv [2];
  logic                                        buf_sing [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign en       = (cnt != 2'd2);
  assign in_stall = !en;
  assign push     = en && vpipe[LAT-1];
  assign pop      = out_valid && !out_stall;
  assign out_valid = (cnt != 2'd0);

  assign m_in[0] = a00;
  assign m_in[1] = a01;
  assign m_in[2] = a02;
  assign m_in[3] = a10;
  assign m_in[4] = a11;
  assign m_in[5] = a12;
  assign m_in[6] = a20;
  assign m_in[7] = a21;
  assign m_in[8] = a22;

  mi3_cofactor #(
    .IN_WIDTH (IN_WIDTH)
  ) u_cofactor (
    .clk   (clk),
    .en    (en),
    .m     (m_in),
    .adj   (adj),
    .det   (det),
    .m_out (m_d)
  );

  for (genvar i = 0; i < mi3_pkg::NUM_ELEM; i++) begin : g_lane
    mi3_div_lane #(
      .IN_WIDTH  (IN_WIDTH),
      .OUT_WIDTH (OUT_WIDTH)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .adj  (adj[i]),
      .det  (det),
      .m    (m_d[i]),
      .res  (res[i]),
      .sing (sing[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  // merge the lanes into the output buffer
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
        buf_inv[wr_ptr][i] <= res[i];
      end
      buf_sing[wr_ptr] <= sing[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  assign inv00    = buf_inv[rd_ptr][0];
  assign inv01    = buf_inv[rd_ptr][1];
  assign inv02    = buf_inv[rd_ptr][2];
  assign inv10    = buf_inv[rd_ptr][3];
  assign inv11    = buf_inv[rd_ptr][4];
  assign inv12    = buf_inv[rd_ptr][5];
  assign inv20    = buf_inv[rd_ptr][6];
  assign inv21    = buf_inv[rd_ptr][7];
  assign inv22    = buf_inv[rd_ptr][8];
  assign singular = buf_sing[rd_ptr];

  `CHK_ALWAYS(a_no_overflow, !(vpipe[LAT-1] && cnt == 2'd2 && !en) || !push)
  `CHK_ALWAYS(a_cnt_range, cnt != 2'd3)
  `CHK_NEXT(a_cnt_up, push && !pop, cnt == $past(cnt) + 2'd1)
  `CHK_NEXT(a_accept_enters, in_valid && !in_stall, vpipe[0])
endmodule

// ===== tb/mi3_checker.sv =====
`timescale 1ns / 1ps
module mi3_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12,
  input  logic signed [31:0] inv20, inv21, inv22,
  input  logic               singular,
  output int                 errors,
  output int                 pending
);
  typedef struct packed {
    logic [mi3_pkg::NUM_ELEM-1:0][31:0] el;
    logic                               sing;
  } inverse_t;

  inverse_t expected_inverses[$];

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic inverse_t invert_matrix(logic [mi3_pkg::NUM_ELEM-1:0][15:0] a);
    longint m[mi3_pkg::NUM_ELEM];
    longint adj[mi3_pkg::NUM_ELEM];
    longint det;
    inverse_t r;
    for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) m[i] = longint'($signed(a[i]));
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[2] * m[7] - m[1] * m[8];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[0] * m[8] - m[2] * m[6];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[1] * m[6] - m[0] * m[7];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    r.sing = (det == 0);
    for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
      r.el[i] = r.sing ? clamp32(m[i] <<< mi3_pkg::PASS_SHIFT)
                       : clamp32((adj[i] <<< mi3_pkg::DIV_SHIFT) / det);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = expected_inverses.size();

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_inverses.push_back(invert_matrix({a22, a21, a20, a12, a11, a10, a02, a01, a00}));
    if (!rst && out_valid && !out_stall) begin
      if (expected_inverses.size() == 0) begin
        report_mismatch("unexpected item", '0, '0);
      end else begin
        inverse_t e;
        logic [mi3_pkg::NUM_ELEM-1:0][31:0] got;
        e = expected_inverses.pop_front();
        got = {inv22, inv21, inv20, inv12, inv11, inv10, inv02, inv01, inv00};
        for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
          if (got[i] !== e.el[i])
            report_mismatch($sformatf("inv%0d%0d", i / 3, i % 3), got[i], e.el[i]);
        if (singular !== e.sing)
          report_mismatch("singular", {31'b0, singular}, {31'b0, e.sing});
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_stall = 0;
  logic signed [15:0] a00 = 0, a01 = 0, a02 = 0, a10 = 0, a11 = 0, a12 = 0;
  logic signed [15:0] a20 = 0, a21 = 0, a22 = 0;
  logic in_stall, out_valid, singular;
  logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  int errors, pending;
  bit calm = 0;

  always #2 clk = ~clk;

  matrix_inverse_3x3_top dut (.*);
  mi3_checker chk (.*);

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_matrix(logic [8:0][15:0] m);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {a22, a21, a20, a12, a11, a10, a02, a01, a00} <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 38);

  initial begin
    logic [8:0][15:0] m;
    int k;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_matrix('0);
    send_matrix({9{16'h8000}});
    send_matrix({9{16'h7fff}});
    send_matrix({16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
    send_matrix({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001});
    send_matrix({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000});
    send_matrix({16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0001});
    send_matrix({16'h0, 16'h0, 16'h0001, 16'h0, 16'h8000, 16'h0, 16'h7fff, 16'h0, 16'h0});
    send_matrix({16'h0300, 16'h0200, 16'h0100, 16'h0600, 16'h0400, 16'h0200,
                 16'h8000, 16'h7fff, 16'h1234});
    send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 16'h8000, 16'h7fff, 16'h8000});
    for (k = 0; k < 450; k++) begin
      calm = (k >= 150 && k < 230);
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      case ($urandom_range(0, 9))
        0: m[8:6] = m[5:3];
        1: begin m[1] = 0; m[2] = 0; m[3] = 0; m[5] = 0; m[6] = 0; m[7] = 0; end
        2: m[5:3] = 0;
        default: ;
      endcase
      send_matrix(m);
    end
    in_valid <= 0;
    calm = 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_cofactor.sv
rtl/mi3_div_lane.sv
rtl/matrix_inverse_3x3_top.sv
tb/mi3_checker.sv
tb/tb.sv
